/* hdl/ssc_pkg.sv */
package ssc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MUL_CHUNK       = 32;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

    localparam logic [1:0] FEAT_START    = 2'd0;
    localparam logic [1:0] FEAT_END      = 2'd1;
    localparam logic [1:0] FEAT_INTERIOR = 2'd2;

endpackage

/* hdl/ssc_dly.sv */
module ssc_dly
    import ssc_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [DW-1:0] i_d,
    output logic [DW-1:0] o_q
);

    logic [DW-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_line[k] <= '0;
        end else if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

/* hdl/ssc_mul.sv */
module ssc_mul
    import ssc_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 68,
    parameter int CW = MUL_CHUNK
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int NA  = (AW + CW - 1) / CW;
    localparam int NB  = (BW + CW - 1) / CW;
    localparam int NS  = NA * NB;
    localparam int APW = NA * CW;
    localparam int BPW = NB * CW;
    localparam int PW  = AW + BW;
    localparam int FW  = APW + BPW;

    logic [APW-1:0] r_a   [NS];
    logic [BPW-1:0] r_b   [NS];
    logic [PW-1:0]  r_acc [NS];

    // one chunk-by-chunk partial product per stage
    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam int IA = g / NB;
        localparam int IB = g % NB;
        localparam int SH = IA * CW + IB * CW;
        logic [APW-1:0]  a_in;
        logic [BPW-1:0]  b_in;
        logic [PW-1:0]   acc_in;
        logic [2*CW-1:0] pp;
        logic [FW-1:0]   part;

        if (g == 0) begin : g_first
            assign a_in   = APW'(i_a);
            assign b_in   = BPW'(i_b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[g-1];
            assign b_in   = r_b[g-1];
            assign acc_in = r_acc[g-1];
        end

        assign pp   = a_in[IA*CW +: CW] * b_in[IB*CW +: CW];
        assign part = FW'(pp) << SH;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[g]   <= a_in;
                r_b[g]   <= b_in;
                r_acc[g] <= acc_in + part[PW-1:0];
            end
        end
    end

    assign o_p = r_acc[NS-1];

endmodule

/* hdl/ssc_div.sv */
module ssc_div
    import ssc_pkg::*;
#(
    parameter int NW = 101,
    parameter int DW = 68,
    parameter int QW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int RMW = DW + 1;

    logic [RMW-1:0] r_rem [QW];
    logic [QW-1:0]  r_low [QW];
    logic [DW-1:0]  r_den [QW];
    logic [QW-1:0]  r_quo [QW];

    // restoring division, one quotient bit per stage; the quotient is known
    // to fit QW bits, so the upper numerator bits seed the remainder
    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int BI = QW - 1 - g;
        logic [RMW-1:0] rem_in;
        logic [QW-1:0]  low_in;
        logic [DW-1:0]  den_in;
        logic [QW-1:0]  quo_in;
        logic [RMW-1:0] sh;
        logic           ge;

        if (g == 0) begin : g_first
            assign rem_in = RMW'(i_num >> QW);
            assign low_in = i_num[QW-1:0];
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign low_in = r_low[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        assign sh = {rem_in[RMW-2:0], low_in[BI]};
        assign ge = sh >= RMW'(den_in);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? sh - RMW'(den_in) : sh;
                r_low[g] <= low_in;
                r_den[g] <= den_in;
                r_quo[g] <= {quo_in[QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

/* hdl/ssc_sqrt.sv */
module ssc_sqrt
    import ssc_pkg::*;
#(
    parameter int RW = 31
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_x,
    output logic [RW-1:0]   o_root
);

    localparam int RMW = RW + 3;

    logic [RMW-1:0]  r_rem  [RW];
    logic [2*RW-1:0] r_x    [RW];
    logic [RW-1:0]   r_root [RW];

    // digit-by-digit square root, two radicand bits per stage
    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int BI = 2 * (RW - 1 - g);
        logic [RMW-1:0]  rem_in;
        logic [2*RW-1:0] x_in;
        logic [RW-1:0]   root_in;
        logic [RMW-1:0]  sh;
        logic [RMW-1:0]  trial;
        logic            ge;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign x_in    = i_x;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign x_in    = r_x[g-1];
            assign root_in = r_root[g-1];
        end

        assign sh    = {rem_in[RMW-3:0], x_in[BI +: 2]};
        assign trial = RMW'({root_in, 2'b01});
        assign ge    = sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? sh - trial : sh;
                r_x[g]    <= x_in;
                r_root[g] <= {root_in[RW-2:0], ge};
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

/* hdl/segment_sphere_closest_point.sv */
// Throughput: one item per cycle while the skid is empty; the long dividers and the
// square root are fully pipelined, one result bit per stage. A one-entry skid absorbs
// the first stalled output, and input is closed while it is full.
// Reset (synchronous, active low) empties the pipeline, clears the centre, radius = 1.0.
module segment_sphere_closest_point
    import ssc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int TIW = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int TOW = ((6 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [TIW-1:0]         s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // surface_x, surface_y, surface_z, seg_x, seg_y, seg_z, feature
    output logic [TOW-1:0]         m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [COORD_WIDTH-1:0] i_cfg_wdata
);

    localparam int W   = COORD_WIDTH;
    localparam int D   = W + 1;
    localparam int S   = 2 * D + 2;
    localparam int RW  = W - 1;
    localparam int XW  = D + RW;
    localparam int CH  = MUL_CHUNK;
    localparam int M1  = ((D + CH - 1) / CH) * ((S + CH - 1) / CH);
    localparam int M2  = ((XW + CH - 1) / CH) * ((XW + CH - 1) / CH);
    localparam int C1W = 6 * W + 6;
    localparam int C2W = 3 * W + 7;
    localparam int FB  = 6 * W;

    logic en;

    // configuration
    logic signed [W-1:0] r_cen [3];
    logic [RW-1:0]       r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen[0] <= '0;
            r_cen[1] <= '0;
            r_cen[2] <= '0;
            r_rad    <= RW'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CENTER_X: r_cen[0] <= i_cfg_wdata;
                CFG_CENTER_Y: r_cen[1] <= i_cfg_wdata;
                CFG_CENTER_Z: r_cen[2] <= i_cfg_wdata;
                CFG_RADIUS:   r_rad    <= i_cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // valid bits and skid
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_g_v, r_h_v, r_o_v, r_sk_v;
    logic c1_v, c2_v;
    logic [TOW-1:0] r_o_data, r_sk_data;

    assign en            = ~r_sk_v;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_sk_v | r_o_v;
    assign m_axis_tdata  = r_sk_v ? r_sk_data : r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_d_v  <= 1'b0;
            r_e_v  <= 1'b0;
            r_f_v  <= 1'b0;
            r_g_v  <= 1'b0;
            r_h_v  <= 1'b0;
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else begin
            if (en) begin
                r_a_v <= s_axis_tvalid;
                r_b_v <= r_a_v;
                r_c_v <= r_b_v;
                r_d_v <= r_c_v;
                r_e_v <= r_d_v;
                r_f_v <= c1_v;
                r_g_v <= r_f_v;
                r_h_v <= r_g_v;
                r_o_v <= c2_v;
            end
            if (r_sk_v) begin
                if (m_axis_tready) r_sk_v <= 1'b0;
            end else if (r_o_v && !m_axis_tready) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) r_sk_data <= r_o_data;
    end

    // stage A: input register
    logic signed [W-1:0] r_a_s [3], r_a_e [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_s[i] <= s_axis_tdata[i*W +: W];
                r_a_e[i] <= s_axis_tdata[(3+i)*W +: W];
            end
        end
    end

    // stage B: differences as magnitude and sign
    logic signed [D-1:0] b_d [3], b_w [3], b_x [3];
    logic [D-1:0] r_b_dm [3], r_b_wm [3], r_b_xm [3];
    logic         r_b_dn [3], r_b_wn [3];
    logic signed [W-1:0] r_b_s [3], r_b_e [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_d[i] = D'(r_a_e[i]) - D'(r_a_s[i]);
            b_w[i] = D'(r_cen[i]) - D'(r_a_s[i]);
            b_x[i] = D'(r_a_e[i]) - D'(r_cen[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_dm[i] <= b_d[i][D-1] ? D'(-b_d[i]) : D'(b_d[i]);
                r_b_wm[i] <= b_w[i][D-1] ? D'(-b_w[i]) : D'(b_w[i]);
                r_b_xm[i] <= b_x[i][D-1] ? D'(-b_x[i]) : D'(b_x[i]);
                r_b_dn[i] <= b_d[i][D-1];
                r_b_wn[i] <= b_w[i][D-1];
                r_b_s[i]  <= r_a_s[i];
                r_b_e[i]  <= r_a_e[i];
            end
        end
    end

    // stage C: products
    logic [2*D-1:0] r_c_dd [3], r_c_wd [3], r_c_xx [3], r_c_ww [3];
    logic           r_c_nm [3], r_c_dn [3];
    logic [D-1:0]   r_c_dm [3];
    logic signed [W-1:0] r_c_s [3], r_c_e [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_c_dd[i] <= r_b_dm[i] * r_b_dm[i];
                r_c_wd[i] <= r_b_wm[i] * r_b_dm[i];
                r_c_xx[i] <= r_b_xm[i] * r_b_xm[i];
                r_c_ww[i] <= r_b_wm[i] * r_b_wm[i];
                r_c_nm[i] <= r_b_dn[i] ^ r_b_wn[i];
                r_c_dn[i] <= r_b_dn[i];
                r_c_dm[i] <= r_b_dm[i];
                r_c_s[i]  <= r_b_s[i];
                r_c_e[i]  <= r_b_e[i];
            end
        end
    end

    // stage D: sums (projection split into positive and negative parts)
    logic [S-1:0] d_len2, d_pos, d_neg, d_de, d_ds;
    logic [S-1:0] r_d_len2, r_d_pos, r_d_neg, r_d_de, r_d_ds;
    logic         r_d_dn [3];
    logic [D-1:0] r_d_dm [3];
    logic signed [W-1:0] r_d_s [3], r_d_e [3];

    always_comb begin
        d_len2 = '0;
        d_pos  = '0;
        d_neg  = '0;
        d_de   = '0;
        d_ds   = '0;
        for (int i = 0; i < 3; i++) begin
            d_len2 = d_len2 + S'(r_c_dd[i]);
            if (r_c_nm[i]) d_neg = d_neg + S'(r_c_wd[i]);
            else           d_pos = d_pos + S'(r_c_wd[i]);
            d_de = d_de + S'(r_c_xx[i]);
            d_ds = d_ds + S'(r_c_ww[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_len2 <= d_len2;
            r_d_pos  <= d_pos;
            r_d_neg  <= d_neg;
            r_d_de   <= d_de;
            r_d_ds   <= d_ds;
            for (int i = 0; i < 3; i++) begin
                r_d_dn[i] <= r_c_dn[i];
                r_d_dm[i] <= r_c_dm[i];
                r_d_s[i]  <= r_c_s[i];
                r_d_e[i]  <= r_c_e[i];
            end
        end
    end

    // stage E: classify; a zero-length segment fails both tests and keeps start
    logic         e_int;
    logic [1:0]   r_e_feat;
    logic [S-1:0] r_e_tv, r_e_len2;
    logic         r_e_dn [3];
    logic [D-1:0] r_e_dm [3];
    logic signed [W-1:0] r_e_s [3], r_e_e [3];

    assign e_int = (r_d_pos > r_d_neg) && (r_d_pos < r_d_len2 + r_d_neg);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_feat <= e_int ? FEAT_INTERIOR : ((r_d_de < r_d_ds) ? FEAT_END : FEAT_START);
            r_e_tv   <= r_d_pos - r_d_neg;
            r_e_len2 <= r_d_len2;
            for (int i = 0; i < 3; i++) begin
                r_e_dn[i] <= r_d_dn[i];
                r_e_dm[i] <= r_d_dm[i];
                r_e_s[i]  <= r_d_s[i];
                r_e_e[i]  <= r_d_e[i];
            end
        end
    end

    // interior offset: |d_i| * t / |d|^2
    logic [D+S-1:0] m1_p [3];
    logic [S-1:0]   m1_len2;
    logic [D-1:0]   q1 [3];
    logic [C1W-1:0] c1_in, c1_out;

    ssc_dly #(.DW(S), .DEPTH(M1)) u_len2_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_e_len2), .o_q(m1_len2)
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane1
        ssc_mul #(.AW(D), .BW(S), .CW(CH)) u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(r_e_dm[l]), .i_b(r_e_tv), .o_p(m1_p[l])
        );
        ssc_div #(.NW(D + S), .DW(S), .QW(D)) u_div (
            .i_clk(i_clk), .i_en(en), .i_num(m1_p[l]), .i_den(m1_len2), .o_quo(q1[l])
        );
    end

    always_comb begin
        c1_in = '0;
        for (int i = 0; i < 3; i++) begin
            c1_in[i*W +: W]     = r_e_s[i];
            c1_in[(3+i)*W +: W] = r_e_e[i];
            c1_in[6*W + i]      = r_e_dn[i];
        end
        c1_in[6*W+3 +: 2] = r_e_feat;
        c1_in[6*W+5]      = r_e_v;
    end

    ssc_dly #(.DW(C1W), .DEPTH(M1 + D)) u_ctx1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(c1_in), .o_q(c1_out)
    );

    logic [1:0] c1_feat;
    assign c1_feat = c1_out[6*W+3 +: 2];
    assign c1_v    = c1_out[6*W+5];

    // stage F: segment point and offset from centre
    logic signed [W+1:0] f_q [3], f_s2 [3], f_t [3];
    logic signed [W-1:0] f_seg [3];
    logic signed [D-1:0] f_v [3];
    logic signed [W-1:0] r_f_seg [3];
    logic [D-1:0]        r_f_vm [3];
    logic                r_f_vn [3];
    logic [1:0]          r_f_feat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_q[i]  = (W+2)'(q1[i]);
            f_s2[i] = (W+2)'($signed(c1_out[i*W +: W]));
            f_t[i]  = c1_out[6*W + i] ? f_s2[i] - f_q[i] : f_s2[i] + f_q[i];
            if (c1_feat == FEAT_INTERIOR)  f_seg[i] = f_t[i][W-1:0];
            else if (c1_feat == FEAT_END)  f_seg[i] = c1_out[(3+i)*W +: W];
            else                           f_seg[i] = c1_out[i*W +: W];
            f_v[i] = D'(f_seg[i]) - D'(r_cen[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_feat <= c1_feat;
            for (int i = 0; i < 3; i++) begin
                r_f_seg[i] <= f_seg[i];
                r_f_vm[i]  <= f_v[i][D-1] ? D'(-f_v[i]) : D'(f_v[i]);
                r_f_vn[i]  <= f_v[i][D-1];
            end
        end
    end

    // stage G: v^2 and |v| * radius
    logic [2*D-1:0]      r_g_v2 [3];
    logic [XW-1:0]       r_g_x [3];
    logic                r_g_lz;
    logic                r_g_vn [3];
    logic signed [W-1:0] r_g_seg [3];
    logic [1:0]          r_g_feat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_lz   <= (r_f_vm[0] == '0) && (r_f_vm[1] == '0) && (r_f_vm[2] == '0);
            r_g_feat <= r_f_feat;
            for (int i = 0; i < 3; i++) begin
                r_g_v2[i]  <= r_f_vm[i] * r_f_vm[i];
                r_g_x[i]   <= r_f_vm[i] * r_rad;
                r_g_vn[i]  <= r_f_vn[i];
                r_g_seg[i] <= r_f_seg[i];
            end
        end
    end

    // stage H: |v|^2
    logic [S-1:0]        r_h_len;
    logic [XW-1:0]       r_h_x [3];
    logic                r_h_lz;
    logic                r_h_vn [3];
    logic signed [W-1:0] r_h_seg [3];
    logic [1:0]          r_h_feat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_len  <= S'(r_g_v2[0]) + S'(r_g_v2[1]) + S'(r_g_v2[2]);
            r_h_lz   <= r_g_lz;
            r_h_feat <= r_g_feat;
            for (int i = 0; i < 3; i++) begin
                r_h_x[i]   <= r_g_x[i];
                r_h_vn[i]  <= r_g_vn[i];
                r_h_seg[i] <= r_g_seg[i];
            end
        end
    end

    // surface magnitude: isqrt((|v_i| r)^2 / |v|^2)
    logic [2*XW-1:0] m2_p [3];
    logic [S-1:0]    m2_len;
    logic [2*RW-1:0] q2 [3];
    logic [RW-1:0]   rt [3];
    logic [C2W-1:0]  c2_in, c2_out;

    ssc_dly #(.DW(S), .DEPTH(M2)) u_len_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_h_len), .o_q(m2_len)
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane2
        ssc_mul #(.AW(XW), .BW(XW), .CW(CH)) u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(r_h_x[l]), .i_b(r_h_x[l]), .o_p(m2_p[l])
        );
        ssc_div #(.NW(2 * XW), .DW(S), .QW(2 * RW)) u_div (
            .i_clk(i_clk), .i_en(en), .i_num(m2_p[l]), .i_den(m2_len), .o_quo(q2[l])
        );
        ssc_sqrt #(.RW(RW)) u_sqrt (
            .i_clk(i_clk), .i_en(en), .i_x(q2[l]), .o_root(rt[l])
        );
    end

    always_comb begin
        c2_in = '0;
        for (int i = 0; i < 3; i++) begin
            c2_in[i*W +: W] = r_h_seg[i];
            c2_in[3*W + i]  = r_h_vn[i];
        end
        c2_in[3*W+3]    = r_h_lz;
        c2_in[3*W+4 +: 2] = r_h_feat;
        c2_in[3*W+6]    = r_h_v;
    end

    ssc_dly #(.DW(C2W), .DEPTH(M2 + 3 * RW)) u_ctx2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(c2_in), .o_q(c2_out)
    );

    assign c2_v = c2_out[3*W+6];

    // output stage: centre +/- magnitude, saturated; the centre alone when v is zero
    logic signed [W:0]   o_c [3], o_m [3], o_t [3];
    logic signed [W-1:0] o_surf [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_c[i] = (W+1)'(r_cen[i]);
            o_m[i] = (W+1)'(rt[i]);
            o_t[i] = c2_out[3*W + i] ? o_c[i] - o_m[i] : o_c[i] + o_m[i];
            if (c2_out[3*W+3])
                o_surf[i] = r_cen[i];
            else if (o_t[i][W] != o_t[i][W-1])
                o_surf[i] = o_t[i][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            else
                o_surf[i] = o_t[i][W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= TOW'({c2_out[3*W+4 +: 2],
                              c2_out[2*W +: W], c2_out[W +: W], c2_out[0 +: W],
                              o_surf[2], o_surf[1], o_surf[0]});
        end
    end

`ifndef SYNTHESIS
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v && !m_axis_tready |=> r_sk_v && $stable(r_sk_data))
        else $error("skid entry lost or changed while stalled");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |=> $stable(r_o_v) && $stable(r_o_data))
        else $error("pipeline moved while skid was full");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> !s_axis_tready)
        else $error("input accepted while skid full");

    a_feat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FB +: 2] == FEAT_START ||
                           m_axis_tdata[FB +: 2] == FEAT_END ||
                           m_axis_tdata[FB +: 2] == FEAT_INTERIOR))
        else $error("bad feature code on output");
`endif

endmodule
